/* src/frl_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and state codes for the frame rate limiter core.
// No dependencies; the other files in src, apart from frl_ram, use it by scoped names.
package frl_pkg;

  // Window geometry and field widths
  localparam int WINDOW_LEN   = 100;
  localparam int TIME_BITS    = 16;
  localparam int ELAPSED_BITS = 16;
  localparam int TARGET_BITS  = 10;
  localparam int RATE_BITS    = 25;
  localparam int WAIT_BITS    = 10;
  localparam int SPAN_BITS    = 16;
  localparam int ACC_BITS     = 32;
  localparam int DATA_BITS    = 32;
  localparam int ADDR_BITS    = 3;

  localparam int SLOT_BITS  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int COUNT_BITS = $clog2(WINDOW_LEN + 1);
  localparam int SUM_BITS   = TIME_BITS + $clog2(WINDOW_LEN);

  // Rate numerator scale: 1000 ms per second, Q8
  localparam int NUM_K        = 1000 * 256;
  localparam int MS_PER_SEC   = 1000;
  localparam int DEFAULT_RATE = 60 * 256;

  // Serial divider widths
  localparam int NUM_RAW  = $clog2(NUM_K * WINDOW_LEN + 1);
  localparam int NUM_BITS = (NUM_RAW > TARGET_BITS) ? NUM_RAW : TARGET_BITS;
  localparam int DEN_BITS = (SUM_BITS > TARGET_BITS) ? SUM_BITS : TARGET_BITS;
  localparam int STEP_BITS = $clog2(NUM_BITS + 1);

  // Register index and actions
  localparam logic REG_TARGET_RATE = 1'b0;
  localparam logic ACT_FRAME_END   = 1'b0;
  localparam logic ACT_READY_CHECK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TDIV,
    ST_DECIDE,
    ST_RDIV,
    ST_FINISH
  } frl_state_e;

  typedef struct packed {
    logic                start;
    logic [NUM_BITS-1:0] dividend;
    logic [DEN_BITS-1:0] divisor;
  } frl_div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [NUM_BITS-1:0] quotient;
  } frl_div_rsp_t;

endpackage

/* src/frl_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for frame requests and result requests.
// Depends on frl_pkg for the field widths.
interface frl_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [frl_pkg::ELAPSED_BITS-1:0]   elapsed_ms;

  modport source (output valid, output action, output elapsed_ms, input ready);
  modport sink   (input valid, input action, input elapsed_ms, output ready);
endinterface

interface frl_out_if;
  logic                            valid;
  logic                            ready;
  logic [frl_pkg::RATE_BITS-1:0]   rate_q8;
  logic [frl_pkg::WAIT_BITS-1:0]   wait_ms;
  logic [frl_pkg::SPAN_BITS-1:0]   span_ms;
  logic                            ready_res;

  modport source (output valid, output rate_q8, output wait_ms, output span_ms,
                  output ready_res, input ready);
  modport sink   (input valid, input rate_q8, input wait_ms, input span_ms,
                  input ready_res, output ready);
endinterface

/* src/frame_rate_limiter_averager_core.sv */
`timescale 1ns / 1ps
// Frame rate limiter core: tick accumulator, target limiter, moving-average meter.
// Depends on frl_pkg, frl_if, frl_ram and frl_div.
//
// One request is worked at a time and gives exactly one result. Most of the
// work per request is in the bit-serial divider, which makes one quotient bit
// per cycle over 25 steps (NUM_BITS). With a target rate set, every request
// first divides 1000 by the target; a frame end that enters the averaging
// window with a nonzero window sum then divides 256000 * count by that sum.
// From acceptance a request passes through ST_TDIV (with a target set),
// ST_DECIDE, ST_RDIV (second division only) and ST_FINISH, where the result
// is loaded once the output register is free. The core is ready for the next
// request in the cycle after the result is loaded. The 100-entry window sits
// in a RAM with no clearing pass: entries are read only once the window has
// filled. A result waits in an output register, and the next request is taken
// while it waits.
module frame_rate_limiter_averager_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [frl_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [frl_pkg::DATA_BITS-1:0]   pwdata,
  output logic [frl_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready,
  frl_in_if.sink                          in_i,
  frl_out_if.source                       out_o
);

  localparam int CMP_BITS = (frl_pkg::TIME_BITS > frl_pkg::TARGET_BITS) ?
                            frl_pkg::TIME_BITS : frl_pkg::TARGET_BITS;

  frl_pkg::frl_state_e state_q, state_d;

  // Architectural state
  logic [frl_pkg::TARGET_BITS-1:0] target_q;
  logic [frl_pkg::SLOT_BITS-1:0]   slot_q;
  logic [frl_pkg::COUNT_BITS-1:0]  fill_q;
  logic [frl_pkg::SUM_BITS-1:0]    sum_q;
  logic [frl_pkg::SPAN_BITS-1:0]   span_q;
  logic [frl_pkg::ACC_BITS-1:0]    acc_q;
  logic [frl_pkg::RATE_BITS-1:0]   rate_q;

  // Working registers of the current request
  logic                            action_q;
  logic [frl_pkg::TIME_BITS-1:0]   t_q;
  logic [frl_pkg::TARGET_BITS-1:0] tt_q;
  logic [frl_pkg::WAIT_BITS-1:0]   res_wait_q;
  logic                            res_ready_q;

  // Output register
  logic                            out_valid_q;
  logic [frl_pkg::RATE_BITS-1:0]   out_rate_q;
  logic [frl_pkg::WAIT_BITS-1:0]   out_wait_q;
  logic [frl_pkg::SPAN_BITS-1:0]   out_span_q;
  logic                            out_ready_res_q;

  // Control from the output decoder
  logic in_acc;
  logic cfg_we;
  logic ram_we;
  logic load_out;
  logic decide;

  frl_pkg::frl_div_req_t div_req;
  frl_pkg::frl_div_rsp_t div_rsp;

  // Decision datapath
  logic [frl_pkg::TIME_BITS-1:0]   ram_rdata;
  logic [CMP_BITS-1:0]             tt_ext;
  logic [CMP_BITS-1:0]             t_ext;
  logic                            early;
  logic                            push;
  logic                            full;
  logic [frl_pkg::SUM_BITS-1:0]    old_val;
  logic [frl_pkg::SUM_BITS-1:0]    sum_new;
  logic [frl_pkg::COUNT_BITS-1:0]  count_new;
  logic [frl_pkg::NUM_BITS-1:0]    num_new;
  logic [frl_pkg::ACC_BITS:0]      acc_sum;
  logic [frl_pkg::ACC_BITS-1:0]    acc_sat;
  logic [frl_pkg::SLOT_BITS-1:0]   slot_next;

  // Configuration port: pready tied high, one register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == frl_pkg::REG_TARGET_RATE);
  always_comb begin
    prdata = '0;
    if (paddr[2] == frl_pkg::REG_TARGET_RATE) begin
      prdata = frl_pkg::DATA_BITS'(target_q);
    end
  end

  // Window store
  frl_ram #(
    .WIDTH (frl_pkg::TIME_BITS),
    .DEPTH (frl_pkg::WINDOW_LEN)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (t_q),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // Shared serial divider
  frl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Frame decision and window update values
  always_comb begin
    tt_ext    = CMP_BITS'(tt_q);
    t_ext     = CMP_BITS'(t_q);
    early     = (action_q == frl_pkg::ACT_FRAME_END) && (target_q != '0) &&
                (tt_ext > t_ext);
    push      = (action_q == frl_pkg::ACT_FRAME_END) && !early;
    full      = (fill_q == frl_pkg::COUNT_BITS'(frl_pkg::WINDOW_LEN));
    old_val   = full ? frl_pkg::SUM_BITS'(ram_rdata) : '0;
    sum_new   = sum_q - old_val + frl_pkg::SUM_BITS'(t_q);
    count_new = full ? fill_q : fill_q + 1'b1;
    num_new   = frl_pkg::NUM_BITS'(frl_pkg::NUM_K * int'(count_new));
    acc_sum   = {1'b0, acc_q} + (frl_pkg::ACC_BITS + 1)'(t_q);
    acc_sat   = acc_sum[frl_pkg::ACC_BITS] ? '1 : acc_sum[frl_pkg::ACC_BITS-1:0];
    slot_next = (slot_q == frl_pkg::SLOT_BITS'(frl_pkg::WINDOW_LEN - 1)) ?
                '0 : slot_q + 1'b1;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frl_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (target_q != '0) ? frl_pkg::ST_TDIV : frl_pkg::ST_DECIDE;
        end
      end
      frl_pkg::ST_TDIV: begin
        if (div_rsp.done) begin
          state_d = frl_pkg::ST_DECIDE;
        end
      end
      frl_pkg::ST_DECIDE: begin
        state_d = (push && (sum_new != '0)) ? frl_pkg::ST_RDIV : frl_pkg::ST_FINISH;
      end
      frl_pkg::ST_RDIV: begin
        if (div_rsp.done) begin
          state_d = frl_pkg::ST_FINISH;
        end
      end
      frl_pkg::ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = frl_pkg::ST_IDLE;
        end
      end
      default: state_d = frl_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_i.ready       = 1'b0;
    decide           = 1'b0;
    ram_we           = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = frl_pkg::NUM_BITS'(frl_pkg::MS_PER_SEC);
    div_req.divisor  = frl_pkg::DEN_BITS'(target_q);
    unique case (state_q)
      frl_pkg::ST_IDLE: begin
        in_i.ready    = 1'b1;
        div_req.start = in_i.valid && (target_q != '0);
      end
      frl_pkg::ST_DECIDE: begin
        decide           = 1'b1;
        ram_we           = push;
        div_req.start    = push && (sum_new != '0);
        div_req.dividend = num_new;
        div_req.divisor  = frl_pkg::DEN_BITS'(sum_new);
      end
      frl_pkg::ST_FINISH: begin
        load_out = !out_valid_q || out_o.ready;
      end
      default: begin
      end
    endcase
  end

  assign in_acc = in_i.valid && in_i.ready;

  // Architectural state and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frl_pkg::ST_IDLE;
      target_q    <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      span_q      <= '0;
      acc_q       <= '0;
      rate_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        target_q <= pwdata[frl_pkg::TARGET_BITS-1:0];
      end
      // Apply the frame end or ready check
      if (decide) begin
        if (action_q == frl_pkg::ACT_FRAME_END) begin
          acc_q <= acc_sat;
          if (early) begin
            span_q <= frl_pkg::SPAN_BITS'(tt_q);
            rate_q <= frl_pkg::RATE_BITS'({target_q, 8'h00});
          end else begin
            span_q <= frl_pkg::SPAN_BITS'(t_q);
            sum_q  <= sum_new;
            fill_q <= count_new;
            slot_q <= slot_next;
            if (sum_new == '0) begin
              rate_q <= frl_pkg::RATE_BITS'(frl_pkg::DEFAULT_RATE);
            end
          end
        end else if ((target_q != '0) &&
                     !(frl_pkg::ACC_BITS'(tt_q) > acc_q)) begin
          acc_q <= '0;
        end
      end
      // Take the averaged rate from the divider
      if ((state_q == frl_pkg::ST_RDIV) && div_rsp.done) begin
        rate_q <= frl_pkg::RATE_BITS'(div_rsp.quotient);
      end
      // Hold the result until the sink takes it
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q    <= in_i.action;
      t_q         <= frl_pkg::TIME_BITS'(in_i.elapsed_ms);
      res_wait_q  <= '0;
      res_ready_q <= 1'b0;
    end
    if ((state_q == frl_pkg::ST_TDIV) && div_rsp.done) begin
      tt_q <= frl_pkg::TARGET_BITS'(div_rsp.quotient);
    end
    if (decide) begin
      if (early) begin
        res_wait_q <= frl_pkg::WAIT_BITS'(tt_ext - t_ext);
      end
      if (action_q == frl_pkg::ACT_READY_CHECK) begin
        res_ready_q <= (target_q == '0) || !(frl_pkg::ACC_BITS'(tt_q) > acc_q);
      end
    end
    if (load_out) begin
      out_rate_q      <= rate_q;
      out_wait_q      <= res_wait_q;
      out_span_q      <= span_q;
      out_ready_res_q <= res_ready_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.rate_q8   = out_rate_q;
  assign out_o.wait_ms   = out_wait_q;
  assign out_o.span_ms   = out_span_q;
  assign out_o.ready_res = out_ready_res_q;

endmodule

/* src/frl_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/frl_div.sv */
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle over NUM_BITS steps.
// Depends on frl_pkg for widths and the request/response structs.
module frl_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  frl_pkg::frl_div_req_t req_i,
  output frl_pkg::frl_div_rsp_t rsp_o
);

  logic [frl_pkg::NUM_BITS-1:0]  quo_q, quo_d;
  logic [frl_pkg::DEN_BITS-1:0]  rem_q, rem_d;
  logic [frl_pkg::DEN_BITS-1:0]  den_q, den_d;
  logic [frl_pkg::STEP_BITS-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;

  logic [frl_pkg::DEN_BITS:0]    rem_sh;
  logic [frl_pkg::DEN_BITS:0]    diff;

  // One restoring step: shift in the next dividend bit, trial subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[frl_pkg::NUM_BITS-1]};
    diff   = rem_sh - {1'b0, den_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[frl_pkg::DEN_BITS]) begin
        rem_d = diff[frl_pkg::DEN_BITS-1:0];
        quo_d = {quo_q[frl_pkg::NUM_BITS-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[frl_pkg::DEN_BITS-1:0];
        quo_d = {quo_q[frl_pkg::NUM_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == frl_pkg::STEP_BITS'(frl_pkg::NUM_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* src/frl_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the frame rate limiter core, bound to the top level.
// Depends on frl_pkg and frame_rate_limiter_averager_core.
module frl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [frl_pkg::RATE_BITS-1:0]   rate_q8_i,
  input logic [frl_pkg::WAIT_BITS-1:0]   wait_ms_i,
  input logic [frl_pkg::SPAN_BITS-1:0]   span_ms_i,
  input logic                            ready_res_i
);

  // Hold a stalled result and its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(rate_q8_i) && $stable(wait_ms_i) &&
       $stable(span_ms_i) && $stable(ready_res_i)))
    else $error("stalled result changed");

  // One request at a time: no request right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request taken while another is in work");

  // A result with ready set never asks for a wait
  a_ready_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && ready_res_i) |-> (wait_ms_i == '0))
    else $error("ready result with nonzero wait");

  // A limited frame reports the whole-number target rate
  a_wait_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (wait_ms_i != '0)) |-> (rate_q8_i[7:0] == 8'h00))
    else $error("limited frame rate has a fraction");

endmodule

bind frame_rate_limiter_averager_core frl_checker u_frl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .rate_q8_i   (out_o.rate_q8),
  .wait_ms_i   (out_o.wait_ms),
  .span_ms_i   (out_o.span_ms),
  .ready_res_i (out_o.ready_res)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the frame rate limiter core: directed and random requests,
// APB target-rate writes with readback, results checked against an in-bench predictor.
// Depends on frl_pkg, frl_if and the core under src.
module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_ITEMS  = 175;
  localparam logic [frl_pkg::ADDR_BITS-1:0] TARGET_ADDR =
    frl_pkg::ADDR_BITS'(4 * int'(frl_pkg::REG_TARGET_RATE));

  typedef struct packed {
    logic [frl_pkg::RATE_BITS-1:0] rate_q8;
    logic [frl_pkg::WAIT_BITS-1:0] wait_ms;
    logic [frl_pkg::SPAN_BITS-1:0] span_ms;
    logic                          ready_res;
  } frame_result_t;

  // Tracks limiter and meter state; predicts one result per accepted request
  class frame_meter_sb;
    logic [frl_pkg::TARGET_BITS-1:0] target;
    logic [frl_pkg::TIME_BITS-1:0]   window [frl_pkg::WINDOW_LEN];
    int unsigned                     slot;
    int unsigned                     fill;
    longint unsigned                 sum;
    logic [frl_pkg::SPAN_BITS-1:0]   span;
    longint unsigned                 ticks;
    logic [frl_pkg::RATE_BITS-1:0]   rate;
    int                              errors;
    frame_result_t                   pending_results [$];

    function new();
      target = '0;
      slot   = 0;
      fill   = 0;
      sum    = 0;
      span   = '0;
      ticks  = 0;
      rate   = '0;
      errors = 0;
    endfunction

    function void set_target(logic [frl_pkg::TARGET_BITS-1:0] value);
      target = value;
    endfunction

    function longint unsigned frame_ticks();
      return (target == 0) ? 0 : frl_pkg::MS_PER_SEC / target;
    endfunction

    function void note_request(logic act, logic [frl_pkg::ELAPSED_BITS-1:0] ms);
      frame_result_t   r;
      longint unsigned tt;
      longint unsigned t;
      r  = '0;
      tt = frame_ticks();
      t  = 64'(ms);
      if (act == frl_pkg::ACT_FRAME_END) begin
        // accumulate with saturation at 32 bits
        ticks = ticks + t;
        if (ticks > 64'hFFFF_FFFF) ticks = 64'hFFFF_FFFF;
        if (target != 0 && tt > t) begin
          // early frame: report the wait and the target rate
          r.wait_ms = frl_pkg::WAIT_BITS'(tt - t);
          span      = frl_pkg::SPAN_BITS'(tt);
          rate      = frl_pkg::RATE_BITS'({target, 8'h00});
        end else begin
          // advance the moving-average window
          span = frl_pkg::SPAN_BITS'(t);
          if (fill >= frl_pkg::WINDOW_LEN) sum -= window[slot];
          else fill++;
          window[slot] = frl_pkg::TIME_BITS'(t);
          sum += t;
          slot = (slot + 1) % frl_pkg::WINDOW_LEN;
          if (sum == 0) rate = frl_pkg::RATE_BITS'(frl_pkg::DEFAULT_RATE);
          else rate = frl_pkg::RATE_BITS'((64'(frl_pkg::NUM_K) * fill) / sum);
        end
      end else begin
        // ready check clears the accumulator only under a target
        if (target == 0) begin
          r.ready_res = 1'b1;
        end else if (tt <= ticks) begin
          ticks       = 0;
          r.ready_res = 1'b1;
        end
      end
      r.rate_q8 = rate;
      r.span_ms = span;
      pending_results.push_back(r);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: rate_q8 %0d", got.rate_q8);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.rate_q8 !== want.rate_q8) begin
        $error("rate_q8 mismatch: expected %0d, got %0d", want.rate_q8, got.rate_q8);
        errors++;
      end
      if (got.wait_ms !== want.wait_ms) begin
        $error("wait_ms mismatch: expected %0d, got %0d", want.wait_ms, got.wait_ms);
        errors++;
      end
      if (got.span_ms !== want.span_ms) begin
        $error("span_ms mismatch: expected %0d, got %0d", want.span_ms, got.span_ms);
        errors++;
      end
      if (got.ready_res !== want.ready_res) begin
        $error("ready_res mismatch: expected %0d, got %0d", want.ready_res, got.ready_res);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [frl_pkg::ADDR_BITS-1:0] paddr;
  logic [frl_pkg::DATA_BITS-1:0] pwdata;
  logic [frl_pkg::DATA_BITS-1:0] prdata;
  logic                          pready;

  frl_in_if  in_bus ();
  frl_out_if out_bus ();

  frame_meter_sb sb = new();

  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_requests;
  int hold_served;
  int cfg_errors;
  int cycles;

  frame_rate_limiter_averager_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_bus),
    .out_o   (out_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("frame_rate_limiter_averager_core regression: fail");
      $finish;
    end
  end

  // Drain results: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready)
        sb.check_result({out_bus.rate_q8, out_bus.wait_ms, out_bus.span_ms,
                         out_bus.ready_res});
      if (hold_served < hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Write the target rate over APB, then read it back
  task automatic write_target(input logic [frl_pkg::TARGET_BITS-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TARGET_ADDR;
    pwdata  <= frl_pkg::DATA_BITS'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_target(value);
    @(posedge clk_i);
    psel    <= 1'b1;
    paddr   <= TARGET_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    if (prdata[frl_pkg::TARGET_BITS-1:0] !== value) begin
      $error("target_rate readback mismatch: expected %0d, got %0d", value,
             prdata[frl_pkg::TARGET_BITS-1:0]);
      cfg_errors++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one request and hold it until accepted
  task automatic send_request(input logic act, input logic [frl_pkg::ELAPSED_BITS-1:0] ms);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.action     <= act;
    in_bus.elapsed_ms <= ms;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_request(act, ms);
  endtask

  // Drop valid and hold until every outstanding result has arrived
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Frame times biased toward the early-frame boundary and small values
  function automatic logic [frl_pkg::ELAPSED_BITS-1:0] pick_elapsed();
    int unsigned sel;
    int unsigned tt;
    sel = $urandom_range(99);
    tt  = int'(sb.frame_ticks());
    if (sel < 35) return frl_pkg::ELAPSED_BITS'($urandom_range(tt + 3, 0));
    if (sel < 60) return frl_pkg::ELAPSED_BITS'($urandom_range(200, 0));
    if (sel < 90) return frl_pkg::ELAPSED_BITS'($urandom);
    return $urandom_range(1) ? '1 : '0;
  endfunction

  initial begin : stimulus
    logic [frl_pkg::TARGET_BITS-1:0] phase_target;
    logic                            act;
    snd_idle_pct      = 0;
    rcv_idle_pct      = 0;
    hold_requests     = 0;
    cfg_errors        = 0;
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.action     <= frl_pkg::ACT_FRAME_END;
    in_bus.elapsed_ms <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // No limit: zero-sum default rate, field extremes, ready always set
    write_target('0);
    send_request(frl_pkg::ACT_FRAME_END, 16'h0000);
    send_request(frl_pkg::ACT_FRAME_END, 16'hFFFF);
    send_request(frl_pkg::ACT_FRAME_END, 16'hAAAA);
    send_request(frl_pkg::ACT_FRAME_END, 16'h5555);
    send_request(frl_pkg::ACT_READY_CHECK, 16'hFFFF);
    drain();

    // Slowest target: early frames, longest wait, ready and not ready
    write_target(10'd1);
    send_request(frl_pkg::ACT_READY_CHECK, 16'h0000);
    send_request(frl_pkg::ACT_FRAME_END, 16'd999);
    send_request(frl_pkg::ACT_FRAME_END, 16'd0);
    send_request(frl_pkg::ACT_READY_CHECK, 16'h0000);
    send_request(frl_pkg::ACT_FRAME_END, 16'd1000);
    send_request(frl_pkg::ACT_READY_CHECK, 16'h0000);
    send_request(frl_pkg::ACT_READY_CHECK, 16'h0000);
    drain();

    // Fastest valid target: one tick per frame
    write_target(10'd1000);
    send_request(frl_pkg::ACT_FRAME_END, 16'd0);
    send_request(frl_pkg::ACT_FRAME_END, 16'd1);
    send_request(frl_pkg::ACT_READY_CHECK, 16'h0000);
    drain();

    // Target above 1000: zero frame time, nothing is early
    write_target(10'd1023);
    send_request(frl_pkg::ACT_FRAME_END, 16'd0);
    send_request(frl_pkg::ACT_READY_CHECK, 16'h0000);
    drain();

    write_target(10'd60);
    send_request(frl_pkg::ACT_FRAME_END, 16'd10);
    send_request(frl_pkg::ACT_READY_CHECK, 16'h0000);
    drain();

    // Random phases over several targets and idle patterns
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: phase_target = '0;
        1: phase_target = frl_pkg::TARGET_BITS'($urandom_range(120, 1));
        2: phase_target = 10'd1000;
        3: phase_target = 10'd1;
        4: phase_target = 10'd1023;
        default: phase_target = frl_pkg::TARGET_BITS'($urandom_range(1023, 1));
      endcase
      if (phase < 2) begin
        snd_idle_pct = 11;
        rcv_idle_pct = 68;
      end else if (phase < 4) begin
        snd_idle_pct = 68;
        rcv_idle_pct = 11;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_target(phase_target);
      // back up the output while requests keep coming
      if (phase == 4) hold_requests++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        act = ($urandom_range(99) < 25) ? frl_pkg::ACT_READY_CHECK
                                        : frl_pkg::ACT_FRAME_END;
        send_request(act, pick_elapsed());
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
    end
    if (sb.errors == 0 && cfg_errors == 0 && sb.pending() == 0) begin
      $display("frame_rate_limiter_averager_core regression: pass");
    end else begin
      $display("frame_rate_limiter_averager_core regression: fail");
    end
    $finish;
  end

endmodule

/* frame_rate_limiter_averager_core.f */
src/frl_pkg.sv
src/frl_if.sv
src/frl_ram.sv
src/frl_div.sv
src/frame_rate_limiter_averager_core.sv
src/frl_checker.sv
tb/sv/tb_top.sv
